// File: hdl/tcrq_pkg.sv
// Package with shared types, codes and constants of the two-class request queue.
`timescale 1ns / 1ps
package tcrq_pkg;

  localparam int CtrlDepthDef = 8;
  localparam int DataDepthDef = 16;
  localparam int PortBitsDef  = 8;
  localparam int TagW         = 16;
  localparam int PortW        = 8;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_LINK = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    PT_DATA  = 2'd0,
    PT_FIN   = 2'd1,
    PT_NACK  = 2'd2,
    PT_OTHER = 2'd3
  } pkg_type_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_LINK_DOWN = 3'd1,
    ST_FULL      = 3'd2,
    ST_CXL_PORT  = 3'd3,
    ST_CXL_LINK  = 3'd4,
    ST_DEQUEUED  = 3'd5,
    ST_EMPTY     = 3'd6,
    ST_STATE_SET = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_PURGE = 2'd1,
    S_ACK   = 2'd2
  } state_t;

  typedef struct packed {
    logic [1:0]      opcode;
    logic [1:0]      pkg_type;
    logic [PortW-1:0] port_id;
    logic [TagW-1:0] req_tag;
    logic            wait_send;
    logic            link_up;
  } in_req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [TagW-1:0]  out_tag;
    logic [PortW-1:0] out_port;
    logic [1:0]       out_type;
    logic             last;
  } out_res_t;

  // Entry of either queue: tag, port, a per-class extra field (type or wait flag).
  typedef struct packed {
    logic [TagW-1:0]  tag;
    logic [PortW-1:0] port;
    logic [1:0]       ext;
  } entry_t;

  // Commands broadcast from the controller to every cell of a queue.
  typedef struct packed {
    logic   push;   // write push_data into the cell at the tail
    logic   shift;  // every cell takes its upper neighbor's entry
    logic   rot;    // purge step: head leaves, kept head re-enters at tail
    entry_t push_data;
  } cell_cmd_t;

endpackage

// File: hdl/tcrq_cell.sv
// One storage cell of a queue chain; takes its neighbor's entry on a shift.
`timescale 1ns / 1ps
module tcrq_cell (
  input  logic                clk,
  input  logic                is_tail,
  input  logic                is_rot_tail,
  input  logic                keep_head,
  input  tcrq_pkg::entry_t    head_in,
  input  tcrq_pkg::cell_cmd_t cmd,
  input  tcrq_pkg::entry_t    nbr_in,
  output tcrq_pkg::entry_t    ent_out
);
  tcrq_pkg::entry_t ent_r, ent_nxt;

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.rot) begin
      ent_nxt = (is_rot_tail && keep_head) ? head_in : nbr_in;
    end else if (cmd.shift) begin
      ent_nxt = nbr_in;
    end else if (cmd.push && is_tail) begin
      ent_nxt = cmd.push_data;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent_out = ent_r;
endmodule

// File: hdl/tcrq_chain.sv
// A row of queue cells with a fill count; the head is cell zero.
`timescale 1ns / 1ps
module tcrq_chain #(
  parameter int Depth = tcrq_pkg::DataDepthDef,
  parameter int CntW  = $clog2(Depth + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tcrq_pkg::cell_cmd_t cmd,
  input  logic                keep_head,
  input  logic [CntW-1:0]     rot_tail,
  input  logic [CntW-1:0]     count_nxt,
  output logic [CntW-1:0]     count,
  output tcrq_pkg::entry_t    head
);
  tcrq_pkg::entry_t ents [Depth];
  logic [CntW-1:0] count_r;

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    tcrq_pkg::entry_t nbr;
    if (g == Depth - 1) begin : g_end
      assign nbr = ents[g];
    end else begin : g_mid
      assign nbr = ents[g+1];
    end
    tcrq_cell u_cell (
      .clk        (clk),
      .is_tail    (count_r == CntW'(g)),
      .is_rot_tail(rot_tail == CntW'(g)),
      .keep_head  (keep_head),
      .head_in    (ents[0]),
      .cmd        (cmd),
      .nbr_in     (nbr),
      .ent_out    (ents[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign count = count_r;
  assign head  = ents[0];
endmodule

// File: hdl/two_class_request_queue_purge_unit.sv
// Top level: control and data request queues with port and link purge.
//
//   channel | ports                    | handshake
//   in      | start, busy, in_req      | accepted when start && !busy
//   out     | out_valid, out_res       | valid marks each result, no stall
//
// Enqueue without purge, dequeue and link writes: one result per request.
// NACK, and FIN while the link is up, walk the data chain once, one head entry a cycle
// by rotation, emitting one cancellation per purged waiting entry.
// Reset empties both queues and marks the link down; no clearing pass.
// The receiver cannot stall; busy holds off new requests until the last result.
`timescale 1ns / 1ps
module two_class_request_queue_purge_unit #(
  parameter int CTRL_DEPTH = tcrq_pkg::CtrlDepthDef,
  parameter int DATA_DEPTH = tcrq_pkg::DataDepthDef,
  parameter int PORT_BITS  = tcrq_pkg::PortBitsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  tcrq_pkg::in_req_t  in_req,
  output logic               out_valid,
  output tcrq_pkg::out_res_t out_res
);
  localparam int CCW = $clog2(CTRL_DEPTH + 1);
  localparam int DCW = $clog2(DATA_DEPTH + 1);

  tcrq_pkg::state_t state_r, state_nxt;
  tcrq_pkg::in_req_t req_r, req_nxt;
  logic link_r, link_nxt;
  logic [DCW-1:0] left_r, left_nxt;  // entries still to inspect
  logic [DCW-1:0] kept_r, kept_nxt;  // entries kept so far
  logic out_valid_r, out_valid_nxt;
  tcrq_pkg::out_res_t out_res_r, out_res_nxt;

  tcrq_pkg::cell_cmd_t ccmd, dcmd;
  logic [CCW-1:0] ccount, ccount_nxt;
  logic [DCW-1:0] dcount, dcount_nxt, rot_tail;
  tcrq_pkg::entry_t chead, dhead;
  logic keep;
  logic [tcrq_pkg::PortW-1:0] port_m;

  assign port_m = in_req.port_id & tcrq_pkg::PortW'((1 << PORT_BITS) - 1);
  assign rot_tail = dcount - DCW'(1);
  assign keep = (req_r.pkg_type == tcrq_pkg::PT_FIN) && (dhead.port != req_r.port_id);

  tcrq_chain #(.Depth(CTRL_DEPTH), .CntW(CCW)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .cmd(ccmd), .keep_head(1'b0), .rot_tail('0),
    .count_nxt(ccount_nxt), .count(ccount), .head(chead)
  );
  tcrq_chain #(.Depth(DATA_DEPTH), .CntW(DCW)) u_data (
    .clk(clk), .rst_n(rst_n), .cmd(dcmd), .keep_head(keep), .rot_tail(rot_tail),
    .count_nxt(dcount_nxt), .count(dcount), .head(dhead)
  );

  always_comb begin
    state_nxt = state_r;
    req_nxt = req_r;
    link_nxt = link_r;
    left_nxt = left_r;
    kept_nxt = kept_r;
    out_valid_nxt = 1'b0;
    out_res_nxt = '0;
    ccmd = '0;
    dcmd = '0;
    ccount_nxt = ccount;
    dcount_nxt = dcount;
    ccmd.push_data = '{tag: req_r.req_tag, port: req_r.port_id, ext: req_r.pkg_type};
    dcmd.push_data = '{tag: req_r.req_tag, port: req_r.port_id,
                       ext: {1'b0, req_r.wait_send}};
    case (state_r)
      tcrq_pkg::S_IDLE: begin
        if (start) begin
          req_nxt = in_req;
          req_nxt.port_id = port_m;
          left_nxt = dcount;
          kept_nxt = '0;
          if (in_req.opcode == tcrq_pkg::OP_ENQ && link_r &&
              (in_req.pkg_type == tcrq_pkg::PT_FIN ||
               in_req.pkg_type == tcrq_pkg::PT_NACK)) begin
            state_nxt = tcrq_pkg::S_PURGE;
          end else if (in_req.opcode != tcrq_pkg::OP_NONE) begin
            state_nxt = tcrq_pkg::S_ACK;
          end
          if (in_req.opcode == tcrq_pkg::OP_ENQ && !link_r &&
              in_req.pkg_type == tcrq_pkg::PT_NACK) begin
            state_nxt = tcrq_pkg::S_PURGE;
          end
        end
      end
      tcrq_pkg::S_PURGE: begin
        if (left_r == '0) begin
          state_nxt = tcrq_pkg::S_ACK;
        end else begin
          // Head leaves; a kept entry re-enters at the tail of the shrinking row.
          dcmd.rot = 1'b1;
          left_nxt = left_r - DCW'(1);
          if (keep) begin
            kept_nxt = kept_r + DCW'(1);
          end else begin
            dcount_nxt = dcount - DCW'(1);
            if (dhead.ext[0]) begin
              out_valid_nxt = 1'b1;
              out_res_nxt.status = (req_r.pkg_type == tcrq_pkg::PT_FIN) ?
                  tcrq_pkg::ST_CXL_PORT : tcrq_pkg::ST_CXL_LINK;
              out_res_nxt.out_tag = dhead.tag;
              out_res_nxt.out_port = dhead.port;
            end
          end
        end
      end
      tcrq_pkg::S_ACK: begin
        state_nxt = tcrq_pkg::S_IDLE;
        out_valid_nxt = 1'b1;
        out_res_nxt.last = 1'b1;
        case (req_r.opcode)
          tcrq_pkg::OP_ENQ: begin
            if (req_r.pkg_type != tcrq_pkg::PT_NACK && !link_r) begin
              out_res_nxt.status = tcrq_pkg::ST_LINK_DOWN;
            end else if (req_r.pkg_type == tcrq_pkg::PT_DATA) begin
              if (dcount == DCW'(DATA_DEPTH)) begin
                out_res_nxt.status = tcrq_pkg::ST_FULL;
              end else begin
                dcmd.push = 1'b1;
                dcount_nxt = dcount + DCW'(1);
                out_res_nxt.status = tcrq_pkg::ST_ACCEPTED;
              end
            end else if (ccount == CCW'(CTRL_DEPTH)) begin
              out_res_nxt.status = tcrq_pkg::ST_FULL;
            end else begin
              ccmd.push = 1'b1;
              ccount_nxt = ccount + CCW'(1);
              out_res_nxt.status = tcrq_pkg::ST_ACCEPTED;
            end
          end
          tcrq_pkg::OP_DEQ: begin
            if (ccount != '0) begin
              ccmd.shift = 1'b1;
              ccount_nxt = ccount - CCW'(1);
              out_res_nxt.status = tcrq_pkg::ST_DEQUEUED;
              out_res_nxt.out_tag = chead.tag;
              out_res_nxt.out_port = chead.port;
              out_res_nxt.out_type = chead.ext;
            end else if (dcount != '0) begin
              dcmd.shift = 1'b1;
              dcount_nxt = dcount - DCW'(1);
              out_res_nxt.status = tcrq_pkg::ST_DEQUEUED;
              out_res_nxt.out_tag = dhead.tag;
              out_res_nxt.out_port = dhead.port;
            end else begin
              out_res_nxt.status = tcrq_pkg::ST_EMPTY;
            end
          end
          tcrq_pkg::OP_LINK: begin
            link_nxt = req_r.link_up;
            out_res_nxt.status = tcrq_pkg::ST_STATE_SET;
          end
          default: begin
            out_valid_nxt = 1'b0;
            out_res_nxt.last = 1'b0;
          end
        endcase
      end
      default: state_nxt = tcrq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcrq_pkg::S_IDLE;
      link_r <= 1'b0;
      out_valid_r <= 1'b0;
      left_r <= '0;
      kept_r <= '0;
    end else begin
      state_r <= state_nxt;
      link_r <= link_nxt;
      out_valid_r <= out_valid_nxt;
      left_r <= left_nxt;
      kept_r <= kept_nxt;
    end
    req_r <= req_nxt;
    out_res_r <= out_res_nxt;
  end

  assign busy = (state_r != tcrq_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res = out_res_r;

  // During a purge the kept entries plus those left always equal the live count.
  a_purge_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tcrq_pkg::S_PURGE |-> (kept_r + left_r) == dcount)
    else $error("purge bookkeeping out of step with data count");
  a_count_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    dcount <= DCW'(DATA_DEPTH) && ccount <= CCW'(CTRL_DEPTH))
    else $error("queue count beyond depth");
  a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tcrq_pkg::S_ACK && req_r.opcode != tcrq_pkg::OP_NONE |=>
      out_valid && out_res.last)
    else $error("final result missing after ack");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r) == tcrq_pkg::S_IDLE |-> !out_valid)
    else $error("result without a request in progress");
endmodule

// File: sim/testbench.sv
// Testbench for the two-class request queue with port and link purge.
`timescale 1ns / 1ps
module testbench;

  class result_board;
    tcrq_pkg::out_res_t due_q[$];
    int errors;
    tcrq_pkg::entry_t ctrl_q[$];
    tcrq_pkg::entry_t data_q[$];
    bit link_on;

    function void push_res(logic [2:0] st, logic [15:0] tg, logic [7:0] pt,
                           logic [1:0] ty);
      tcrq_pkg::out_res_t r;
      r.status = st;
      r.out_tag = tg;
      r.out_port = pt;
      r.out_type = ty;
      r.last = 1'b0;
      due_q.push_back(r);
    endfunction

    // Removes data requests (all, or on one port); waiting ones are cancelled.
    function void purge_data(bit by_port, logic [7:0] pt, logic [2:0] st);
      tcrq_pkg::entry_t kept[$];
      foreach (data_q[i]) begin
        if (!by_port || data_q[i].port == pt) begin
          if (data_q[i].ext[0]) push_res(st, data_q[i].tag, data_q[i].port, 2'd0);
        end else begin
          kept.push_back(data_q[i]);
        end
      end
      data_q = kept;
    endfunction

    function void note_request(tcrq_pkg::in_req_t rq);
      tcrq_pkg::entry_t e;
      int n0;
      n0 = due_q.size();
      e.tag = rq.req_tag;
      e.port = rq.port_id;
      case (rq.opcode)
        tcrq_pkg::OP_ENQ: begin
          if (rq.pkg_type != tcrq_pkg::PT_NACK && !link_on) begin
            push_res(tcrq_pkg::ST_LINK_DOWN, '0, '0, '0);
          end else begin
            if (rq.pkg_type == tcrq_pkg::PT_FIN)
              purge_data(1'b1, rq.port_id, tcrq_pkg::ST_CXL_PORT);
            else if (rq.pkg_type == tcrq_pkg::PT_NACK)
              purge_data(1'b0, '0, tcrq_pkg::ST_CXL_LINK);
            if (rq.pkg_type == tcrq_pkg::PT_DATA) begin
              if (data_q.size() >= tcrq_pkg::DataDepthDef) begin
                push_res(tcrq_pkg::ST_FULL, '0, '0, '0);
              end else begin
                e.ext = {1'b0, rq.wait_send};
                data_q.push_back(e);
                push_res(tcrq_pkg::ST_ACCEPTED, '0, '0, '0);
              end
            end else begin
              if (ctrl_q.size() >= tcrq_pkg::CtrlDepthDef) begin
                push_res(tcrq_pkg::ST_FULL, '0, '0, '0);
              end else begin
                e.ext = rq.pkg_type;
                ctrl_q.push_back(e);
                push_res(tcrq_pkg::ST_ACCEPTED, '0, '0, '0);
              end
            end
          end
        end
        tcrq_pkg::OP_DEQ: begin
          if (ctrl_q.size() > 0) begin
            e = ctrl_q.pop_front();
            push_res(tcrq_pkg::ST_DEQUEUED, e.tag, e.port, e.ext);
          end else if (data_q.size() > 0) begin
            e = data_q.pop_front();
            push_res(tcrq_pkg::ST_DEQUEUED, e.tag, e.port, 2'd0);
          end else begin
            push_res(tcrq_pkg::ST_EMPTY, '0, '0, '0);
          end
        end
        tcrq_pkg::OP_LINK: begin
          link_on = rq.link_up;
          push_res(tcrq_pkg::ST_STATE_SET, '0, '0, '0);
        end
        default: ;
      endcase
      if (due_q.size() > n0) due_q[due_q.size()-1].last = 1'b1;
    endfunction

    function void check_result(tcrq_pkg::out_res_t got);
      tcrq_pkg::out_res_t w;
      if (due_q.size() == 0) begin
        $error("result with nothing expected: status %0d", got.status);
        errors++;
        return;
      end
      w = due_q.pop_front();
      if (got.status !== w.status) begin
        $error("status: expected %0d, got %0d", w.status, got.status); errors++;
      end
      if (got.out_tag !== w.out_tag) begin
        $error("out_tag: expected %0h, got %0h", w.out_tag, got.out_tag); errors++;
      end
      if (got.out_port !== w.out_port) begin
        $error("out_port: expected %0h, got %0h", w.out_port, got.out_port); errors++;
      end
      if (got.out_type !== w.out_type) begin
        $error("out_type: expected %0d, got %0d", w.out_type, got.out_type); errors++;
      end
      if (got.last !== w.last) begin
        $error("last: expected %0d, got %0d", w.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  tcrq_pkg::in_req_t in_req = '0;
  logic out_valid;
  tcrq_pkg::out_res_t out_res;
  int idle_pct = 38;
  result_board board = new();

  two_class_request_queue_purge_unit i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_res(out_res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_result(out_res);
  end

  // Start stays high between requests sent back to back; it drops only while idling.
  task automatic send_request(tcrq_pkg::in_req_t rq);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_req <= rq;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_request(rq);
    @(negedge clk);
  endtask

  task automatic send_fields(logic [1:0] op, logic [1:0] ty, logic [7:0] pt,
                             logic [15:0] tg, logic ws, logic up);
    tcrq_pkg::in_req_t rq;
    rq.opcode = op;
    rq.pkg_type = ty;
    rq.port_id = pt;
    rq.req_tag = tg;
    rq.wait_send = ws;
    rq.link_up = up;
    send_request(rq);
  endtask

  // Mostly enqueues on a few ports so that purges find matching entries.
  task automatic send_random();
    int sel;
    logic [1:0] r_ty;
    logic [7:0] r_pt;
    logic [15:0] r_tg;
    logic r_ws;
    logic r_up;
    sel = $urandom_range(99);
    r_ty = 2'($urandom_range(3));
    r_pt = 8'($urandom_range(255));
    r_tg = 16'($urandom);
    r_ws = 1'($urandom);
    r_up = 1'($urandom);
    if (sel < 55) begin
      if ($urandom_range(99) < 60) r_ty = tcrq_pkg::PT_DATA;
      if ($urandom_range(3) != 0) r_pt = 8'($urandom_range(3));
      send_fields(tcrq_pkg::OP_ENQ, r_ty, r_pt, r_tg, r_ws, r_up);
    end else if (sel < 83) begin
      send_fields(tcrq_pkg::OP_DEQ, r_ty, r_pt, r_tg, r_ws, r_up);
    end else if (sel < 95) begin
      send_fields(tcrq_pkg::OP_LINK, r_ty, r_pt, r_tg, r_ws,
                  $urandom_range(99) < 85);
    end else begin
      send_fields(tcrq_pkg::OP_NONE, r_ty, r_pt, r_tg, r_ws, r_up);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // Directed part: link down, state write, fill, full, purges, empty.
    send_fields(tcrq_pkg::OP_ENQ, tcrq_pkg::PT_DATA, 8'hff, 16'hffff, 1'b1, 1'b1);
    send_fields(tcrq_pkg::OP_DEQ, tcrq_pkg::PT_DATA, '0, '0, 1'b0, 1'b0);
    send_fields(tcrq_pkg::OP_ENQ, tcrq_pkg::PT_NACK, 8'h00, 16'h0000, 1'b0, 1'b0);
    send_fields(tcrq_pkg::OP_LINK, tcrq_pkg::PT_DATA, '0, '0, 1'b0, 1'b1);
    for (int i = 0; i < 17; i++)
      send_fields(tcrq_pkg::OP_ENQ, tcrq_pkg::PT_DATA, (i % 3 == 0) ? 8'hff : 8'h00,
                  16'(16'hffff - i), i[0], 1'b0);
    send_fields(tcrq_pkg::OP_ENQ, tcrq_pkg::PT_FIN, 8'hff, 16'h1234, 1'b1, 1'b0);
    send_fields(tcrq_pkg::OP_ENQ, tcrq_pkg::PT_OTHER, 8'h80, 16'h8000, 1'b0, 1'b1);
    send_fields(tcrq_pkg::OP_ENQ, tcrq_pkg::PT_NACK, 8'h01, 16'h0001, 1'b1, 1'b0);
    send_fields(tcrq_pkg::OP_NONE, tcrq_pkg::PT_OTHER, 8'hff, 16'hffff, 1'b1, 1'b1);
    for (int i = 0; i < 6; i++)
      send_fields(tcrq_pkg::OP_ENQ, tcrq_pkg::PT_OTHER, 8'(i), 16'(i), 1'b0, 1'b0);
    for (int i = 0; i < 11; i++)
      send_fields(tcrq_pkg::OP_DEQ, tcrq_pkg::PT_DATA, '0, '0, 1'b0, 1'b0);
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 38 : (ph == 1) ? 88 : 0;
      for (int i = 0; i < 90; i++) send_random();
    end
    start <= 1'b0;
    while (board.due_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// File: two_class_request_queue_purge_unit.f
hdl/tcrq_pkg.sv
hdl/tcrq_cell.sv
hdl/tcrq_chain.sv
hdl/two_class_request_queue_purge_unit.sv
sim/testbench.sv
